@@ rtl/tcp_congestion_window_update_assert.svh @@
// Assertion macros shared by the congestion window checker.
`ifndef TCP_CONGESTION_WINDOW_UPDATE_ASSERT_SVH
`define TCP_CONGESTION_WINDOW_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("congestion window check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("congestion window check failed");

`endif

@@ rtl/tcw_pkg.sv @@
// Shared widths, codes, state type and saturating add for the congestion window block.
package tcw_pkg;

  localparam int WORD_W    = 32;
  localparam int SEG_W     = 16;
  localparam int ACK_W     = 16;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = WORD_W + SEG_W;
  localparam int DIGIT_W   = 2;
  localparam int DIV_STEPS = WORD_W / DIGIT_W;
  localparam int MUL_STEPS = SEG_W / DIGIT_W;

  localparam logic [SEG_W-1:0]  SEG_RESET    = SEG_W'(1460);
  localparam logic [WORD_W-1:0] WINDOW_RESET = WORD_W'(1460);
  localparam logic [WORD_W-1:0] THRESH_RESET = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACK  = 2'd0,
    FUNC_LOSS = 2'd1,
    FUNC_LOAD = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEGMENT_SIZE      = 2'd0,
    CFG_INITIAL_WINDOW    = 2'd1,
    CFG_INITIAL_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SS,
    ST_SS_ADD,
    ST_SS_SUB,
    ST_DIV_SS,
    ST_SS_LEFT,
    ST_DIV_W,
    ST_AV_BUMP,
    ST_AV_ADD,
    ST_AV_CHECK,
    ST_DIV_ACK,
    ST_MUL_AV,
    ST_AV_GROW,
    ST_FINISH
  } state_e;

  // Adds a wide operand to a word and clamps the sum at the largest word value.
  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                               input logic [PROD_W-1:0] b);
    logic [PROD_W:0] s;
    s = {(PROD_W + 1 - WORD_W)'(0), a} + {1'b0, b};
    if (s[PROD_W:WORD_W] != '0) begin
      return '1;
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

@@ rtl/tcp_congestion_window_update.sv @@
// Top level of the Reno style congestion window block: control, state and result register.
// The block handles one item at a time. A loss, window load or no-operation item goes
// straight from idle to the finish state. A slow-start ack runs the multiplier and then
// the divider; an avoidance ack runs the divider and, when the counted acks fill a window,
// the divider and multiplier once more to divide them out. The shared divider yields two
// quotient bits per cycle and the multiplier takes two segment-size bits per cycle. A new
// item may be accepted while the previous result still waits on the output; a segment size
// of zero acts as one.
module tcp_congestion_window_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::FUNC_W-1:0]    func_i,
  input  logic [tcw_pkg::ACK_W-1:0]     segments_acked_i,
  input  logic [tcw_pkg::WORD_W-1:0]    window_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::WORD_W-1:0]    window_bytes_o,
  output logic [tcw_pkg::WORD_W-1:0]    threshold_bytes_o,
  output logic [tcw_pkg::ACK_W-1:0]     leftover_acked_o,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcw_pkg::WORD_W-1:0]    cfg_wdata_i
);
  import tcw_pkg::*;

  state_e            state_q, state_d;
  logic [WORD_W-1:0] window_q, window_d;
  logic [WORD_W-1:0] thresh_q, thresh_d;
  logic [WORD_W-1:0] ack_q, ack_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic [ACK_W-1:0]  acked_q, acked_d;
  logic [WORD_W-1:0] tmp_q, tmp_d;
  logic [ACK_W-1:0]  left_q, left_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_window_q;
  logic [WORD_W-1:0] out_thresh_q;
  logic [ACK_W-1:0]  out_left_q;
  logic              out_load;

  logic [SEG_W-1:0]  seg_eff;
  logic [WORD_W-1:0] two_seg;
  logic [WORD_W-1:0] half_win;
  logic [WORD_W-1:0] grown;

  logic              div_start;
  logic [WORD_W-1:0] div_dividend;
  logic [WORD_W-1:0] div_divisor;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;
  logic [WORD_W-1:0] div_rem;

  logic              mul_start;
  logic [WORD_W-1:0] mul_mcand;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;

  assign seg_eff  = (seg_q == '0) ? SEG_W'(1) : seg_q;
  assign two_seg  = WORD_W'({seg_eff, 1'b0});
  assign half_win = {1'b0, window_q[WORD_W-1:1]};
  assign grown    = sat_add(window_q, mul_prod);

  tcw_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  tcw_multiplier u_multiplier (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_mcand),
    .mplier_i  (seg_eff),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_comb begin
    state_d      = state_q;
    window_d     = window_q;
    thresh_d     = thresh_q;
    ack_d        = ack_q;
    seg_d        = seg_q;
    acked_d      = acked_q;
    tmp_d        = tmp_q;
    left_d       = left_q;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = window_q;
    div_divisor  = WORD_W'(seg_eff);
    mul_start    = 1'b0;
    mul_mcand    = WORD_W'(segments_acked_i);
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (cfg_we_i) begin
          unique case (cfg_idx_e'(cfg_index_i))
            CFG_SEGMENT_SIZE:      seg_d    = cfg_wdata_i[SEG_W-1:0];
            CFG_INITIAL_WINDOW:    window_d = cfg_wdata_i;
            CFG_INITIAL_THRESHOLD: thresh_d = cfg_wdata_i;
            default: ;
          endcase
        end
        if (in_valid_i) begin
          acked_d = segments_acked_i;
          left_d  = '0;
          state_d = ST_FINISH;
          unique case (func_e'(func_i))
            FUNC_ACK: begin
              if (window_q < thresh_q) begin
                if (segments_acked_i != '0) begin
                  mul_start = 1'b1;
                  state_d   = ST_MUL_SS;
                end
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV_W;
              end
            end
            FUNC_LOSS: thresh_d = (two_seg > half_win) ? two_seg : half_win;
            FUNC_LOAD: window_d = window_value_i;
            FUNC_NOP:  ;
          endcase
        end
      end
      ST_MUL_SS: begin
        if (mul_done) begin
          state_d = ST_SS_ADD;
        end
      end
      ST_SS_ADD: begin
        window_d = (grown < thresh_q) ? grown : thresh_q;
        tmp_d    = window_q;
        state_d  = ST_SS_SUB;
      end
      ST_SS_SUB: begin
        div_start    = 1'b1;
        div_dividend = window_q - tmp_q;
        state_d      = ST_DIV_SS;
      end
      ST_DIV_SS: begin
        if (div_done) begin
          state_d = ST_SS_LEFT;
        end
      end
      ST_SS_LEFT: begin
        if (div_quo >= WORD_W'(acked_q)) begin
          left_d = '0;
        end else begin
          left_d = acked_q - div_quo[ACK_W-1:0];
        end
        state_d = ST_FINISH;
      end
      ST_DIV_W: begin
        if (div_done) begin
          tmp_d   = (div_quo == '0) ? WORD_W'(1) : div_quo;
          state_d = ST_AV_BUMP;
        end
      end
      ST_AV_BUMP: begin
        if (ack_q >= tmp_q) begin
          ack_d    = '0;
          window_d = sat_add(window_q, PROD_W'(seg_eff));
        end
        state_d = ST_AV_ADD;
      end
      ST_AV_ADD: begin
        ack_d   = sat_add(ack_q, PROD_W'(acked_q));
        state_d = ST_AV_CHECK;
      end
      ST_AV_CHECK: begin
        if (ack_q >= tmp_q) begin
          div_start    = 1'b1;
          div_dividend = ack_q;
          div_divisor  = tmp_q;
          state_d      = ST_DIV_ACK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV_ACK: begin
        if (div_done) begin
          ack_d     = div_rem;
          mul_start = 1'b1;
          mul_mcand = div_quo;
          state_d   = ST_MUL_AV;
        end
      end
      ST_MUL_AV: begin
        if (mul_done) begin
          state_d = ST_AV_GROW;
        end
      end
      ST_AV_GROW: begin
        window_d = grown;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      thresh_q    <= THRESH_RESET;
      ack_q       <= '0;
      seg_q       <= SEG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      thresh_q    <= thresh_d;
      ack_q       <= ack_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acked_q <= acked_d;
    tmp_q   <= tmp_d;
    left_q  <= left_d;
    if (out_load) begin
      out_window_q <= window_q;
      out_thresh_q <= thresh_q;
      out_left_q   <= left_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign window_bytes_o    = out_window_q;
  assign threshold_bytes_o = out_thresh_q;
  assign leftover_acked_o  = out_left_q;

endmodule

@@ rtl/tcw_divider.sv @@
// Radix-4 restoring divider that produces two quotient bits per cycle.
module tcw_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tcw_pkg::WORD_W-1:0] dividend_i,
  input  logic [tcw_pkg::WORD_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [tcw_pkg::WORD_W-1:0] quotient_o,
  output logic [tcw_pkg::WORD_W-1:0] remainder_o
);
  import tcw_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] div_q, div_d;
  logic [WORD_W-1:0] rem_n;
  logic [WORD_W-1:0] quo_n;

  always_comb begin
    logic [WORD_W:0] r;
    rem_n = rem_q;
    quo_n = quo_q;
    for (int i = 0; i < DIGIT_W; i++) begin
      r     = {rem_n, quo_n[WORD_W-1]};
      quo_n = {quo_n[WORD_W-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r        = r - {1'b0, div_q};
        quo_n[0] = 1'b1;
      end
      rem_n = r[WORD_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_n;
      quo_d = quo_n;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ rtl/tcw_multiplier.sv @@
// Shift-and-add multiplier that consumes two bits of the segment size per cycle.
module tcw_multiplier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tcw_pkg::WORD_W-1:0] mcand_i,
  input  logic [tcw_pkg::SEG_W-1:0]  mplier_i,
  output logic                       done_o,
  output logic [tcw_pkg::PROD_W-1:0] product_o
);
  import tcw_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] mc_q, mc_d;
  logic [SEG_W-1:0]  mp_q, mp_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] part0;
  logic [PROD_W-1:0] part1;

  assign part0 = mp_q[0] ? mc_q : '0;
  assign part1 = mp_q[1] ? {mc_q[PROD_W-2:0], 1'b0} : '0;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MUL_STEPS - 1);
      mc_d   = PROD_W'(mcand_i);
      mp_d   = mplier_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + part0 + part1;
      mc_d  = {mc_q[PROD_W-1-DIGIT_W:0], DIGIT_W'(0)};
      mp_d  = {DIGIT_W'(0), mp_q[SEG_W-1:DIGIT_W]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checker for the congestion window block and its bind to the top level.
`include "tcp_congestion_window_update_assert.svh"

module tcw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tcw_pkg::WORD_W-1:0]    window_bytes_o,
  input logic [tcw_pkg::WORD_W-1:0]    threshold_bytes_o
);
  import tcw_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `TCW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(window_bytes_o) && $stable(threshold_bytes_o))
  `TCW_ASSERT_SAME(a_result_has_item, out_valid_o, pend_q != 2'd0)
  `TCW_ASSERT_SAME(a_pending_bound, 1'b1, pend_q != 2'd3)
  `TCW_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready_o)

endmodule

bind tcp_congestion_window_update tcw_checker u_tcw_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the Reno style congestion window block.
module tb;
  import tcw_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 60;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CALM_PHASE      = 6;
  localparam int HOLD_PHASE      = 7;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] window;
    logic [WORD_W-1:0] threshold;
    logic [ACK_W-1:0]  leftover;
  } cwnd_result_t;

  typedef struct packed {
    bit                     is_write;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [WORD_W-1:0]      reg_data;
    func_e                  op;
    logic [ACK_W-1:0]       acked;
    logic [WORD_W-1:0]      value;
    bit                     known;
    cwnd_result_t           result;
  } step_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i;
  logic [ACK_W-1:0]     segments_acked_i;
  logic [WORD_W-1:0]    window_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [WORD_W-1:0]    window_bytes_o;
  logic [WORD_W-1:0]    threshold_bytes_o;
  logic [ACK_W-1:0]     leftover_acked_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [WORD_W-1:0]    cfg_wdata_i;

  // Predicted block state.
  logic [SEG_W-1:0]  mss;
  logic [WORD_W-1:0] cwnd;
  logic [WORD_W-1:0] ssthresh;
  logic [WORD_W-1:0] avoid_acks;

  cwnd_result_t expected_windows[$];
  step_t        directed_steps[$];

  int phase_no;
  int mismatches;
  int results_checked;
  int items_sent;
  int directed_items;
  int register_writes;
  int slow_start_acks;
  int avoidance_acks;
  int quiet_cycles;

  tcp_congestion_window_update u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .segments_acked_i  (segments_acked_i),
    .window_value_i    (window_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .window_bytes_o    (window_bytes_o),
    .threshold_bytes_o (threshold_bytes_o),
    .leftover_acked_o  (leftover_acked_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [WORD_W-1:0] clamp_add(input logic [WORD_W-1:0] a,
                                                  input logic [63:0] b);
    logic [64:0] total;
    total = {33'd0, a} + {1'b0, b};
    return (total > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[WORD_W-1:0];
  endfunction

  // Advances the predicted window state by one item and returns the result it reports.
  function automatic cwnd_result_t apply_reno_step(input func_e op, input logic [ACK_W-1:0] acked,
                                                   input logic [WORD_W-1:0] value);
    cwnd_result_t r;
    logic [WORD_W-1:0] seg;
    logic [WORD_W-1:0] prior;
    logic [WORD_W-1:0] grown;
    logic [WORD_W-1:0] used;
    logic [WORD_W-1:0] per_window;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] leftover;
    seg = (mss == '0) ? 32'd1 : {16'd0, mss};
    leftover = '0;
    case (op)
      FUNC_ACK: begin
        if (cwnd < ssthresh) begin
          slow_start_acks++;
          if (acked != '0) begin
            prior = cwnd;
            grown = clamp_add(prior, 64'(acked) * 64'(seg));
            cwnd = (grown < ssthresh) ? grown : ssthresh;
            used = (cwnd >= prior) ? (cwnd - prior) / seg : 32'd0;
            leftover = (used >= 32'(acked)) ? 32'd0 : 32'(acked) - used;
          end
        end else begin
          avoidance_acks++;
          per_window = cwnd / seg;
          if (per_window == '0) per_window = 32'd1;
          if (avoid_acks >= per_window) begin
            avoid_acks = '0;
            cwnd = clamp_add(cwnd, 64'(seg));
          end
          avoid_acks = clamp_add(avoid_acks, 64'(acked));
          if (avoid_acks >= per_window) begin
            delta = avoid_acks / per_window;
            avoid_acks = avoid_acks % per_window;
            cwnd = clamp_add(cwnd, 64'(delta) * 64'(seg));
          end
        end
      end
      FUNC_LOSS: begin
        ssthresh = ((seg << 1) > (cwnd >> 1)) ? (seg << 1) : (cwnd >> 1);
      end
      FUNC_LOAD: begin
        cwnd = value;
      end
      default: begin
      end
    endcase
    r.window = cwnd;
    r.threshold = ssthresh;
    r.leftover = leftover[ACK_W-1:0];
    return r;
  endfunction

  function automatic step_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [WORD_W-1:0] data);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_data = data;
    s.op = FUNC_NOP;
    return s;
  endfunction

  function automatic step_t op_row(input func_e op, input logic [ACK_W-1:0] acked,
                                   input logic [WORD_W-1:0] value);
    step_t s;
    s = '0;
    s.op = op;
    s.acked = acked;
    s.value = value;
    return s;
  endfunction

  function automatic step_t known_row(input func_e op, input logic [ACK_W-1:0] acked,
                                      input logic [WORD_W-1:0] value,
                                      input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] t,
                                      input logic [ACK_W-1:0] l);
    step_t s;
    s = op_row(op, acked, value);
    s.known = 1'b1;
    s.result.window = w;
    s.result.threshold = t;
    s.result.leftover = l;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    end
  endtask

  task automatic send_item(input func_e op, input logic [ACK_W-1:0] acked,
                           input logic [WORD_W-1:0] value, input bit known,
                           input cwnd_result_t typed);
    cwnd_result_t predicted;
    cfg_we_i <= 1'b0;
    if (phase_no != CALM_PHASE && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= op;
    segments_acked_i <= acked;
    window_value_i   <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_reno_step(op, acked, value);
    expected_windows.push_back(known ? typed : predicted);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic config_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SEGMENT_SIZE:      mss = data[SEG_W-1:0];
      CFG_INITIAL_WINDOW:    cwnd = data;
      CFG_INITIAL_THRESHOLD: ssthresh = data;
      default: begin
      end
    endcase
    register_writes++;
  endtask

  // Mostly acks of realistic size, with losses, window loads and no-ops mixed in.
  task automatic send_random_item();
    int pick;
    int size_pick;
    logic [ACK_W-1:0] acked;
    logic [WORD_W-1:0] value;
    pick = $urandom_range(99);
    size_pick = $urandom_range(99);
    value = $urandom();
    if (size_pick < 70) acked = ACK_W'($urandom_range(0, 8));
    else if (size_pick < 90) acked = ACK_W'($urandom_range(0, 1000));
    else acked = ACK_W'($urandom());
    if (pick < 62) begin
      send_item(FUNC_ACK, acked, value, 1'b0, '0);
    end else if (pick < 74) begin
      send_item(FUNC_LOSS, acked, value, 1'b0, '0);
    end else if (pick < 86) begin
      case ($urandom_range(3))
        0: value = '0;
        1: value = '1;
        2: value = $urandom_range(0, 100000);
        default: value = $urandom();
      endcase
      send_item(FUNC_LOAD, acked, value, 1'b0, '0);
    end else if (pick < 95) begin
      send_item(FUNC_NOP, acked, value, 1'b0, '0);
    end else begin
      send_item(FUNC_ACK, ACK_W'($urandom()), value, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cwnd_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_windows.size() == 0) begin
        report_mismatch("result with nothing expected, window", window_bytes_o, '0);
      end else begin
        want = expected_windows.pop_front();
        results_checked++;
        if (window_bytes_o !== want.window) begin
          report_mismatch("window_bytes", window_bytes_o, want.window);
        end
        if (threshold_bytes_o !== want.threshold) begin
          report_mismatch("threshold_bytes", threshold_bytes_o, want.threshold);
        end
        if (leftover_acked_o !== want.leftover) begin
          report_mismatch("leftover_acked", 32'(leftover_acked_o), 32'(want.leftover));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d cycles without an item moving", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, a calm phase, and one long hold-off to back the block up.
  initial begin
    int hold_left;
    bit hold_started;
    hold_left = 0;
    hold_started = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_started && phase_no == HOLD_PHASE) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (phase_no == CALM_PHASE) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    logic [SEG_W-1:0]  seg_set;
    logic [WORD_W-1:0] win_set;
    logic [WORD_W-1:0] thr_set;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    func_i           = FUNC_NOP;
    segments_acked_i = '0;
    window_value_i   = '0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_SEGMENT_SIZE;
    cfg_wdata_i      = '0;
    phase_no         = 0;
    mismatches       = 0;
    results_checked  = 0;
    items_sent       = 0;
    register_writes  = 0;
    slow_start_acks  = 0;
    avoidance_acks   = 0;
    quiet_cycles     = 0;
    mss              = SEG_RESET;
    cwnd             = WINDOW_RESET;
    ssthresh         = THRESH_RESET;
    avoid_acks       = '0;

    directed_steps = '{
      known_row(FUNC_NOP, 16'd0, 32'd0, 32'd1460, 32'hFFFF_FFFF, 16'd0),
      known_row(FUNC_ACK, 16'd0, 32'd0, 32'd1460, 32'hFFFF_FFFF, 16'd0),
      known_row(FUNC_ACK, 16'd3, 32'd0, 32'd5840, 32'hFFFF_FFFF, 16'd0),
      known_row(FUNC_LOAD, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0),
      known_row(FUNC_ACK, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0),
      known_row(FUNC_LOSS, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'd0),
      known_row(FUNC_LOAD, 16'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 16'd0),
      known_row(FUNC_ACK, 16'hFFFF, 32'd0, 32'd95681100, 32'h7FFF_FFFF, 16'd0),
      known_row(FUNC_LOSS, 16'd0, 32'd0, 32'd95681100, 32'd47840550, 16'd0),
      op_row(FUNC_ACK, 16'd1, 32'd0),
      op_row(FUNC_ACK, 16'hFFFF, 32'hFFFF_FFFF),
      op_row(FUNC_NOP, 16'h5555, 32'hAAAA_AAAA),
      write_row(CFG_SEGMENT_SIZE, 32'd0),
      write_row(CFG_INITIAL_THRESHOLD, 32'd8),
      write_row(CFG_INITIAL_WINDOW, 32'd0),
      op_row(FUNC_ACK, 16'd5, 32'd0),
      op_row(FUNC_LOSS, 16'd0, 32'd0),
      op_row(FUNC_ACK, 16'd10, 32'd0),
      write_row(CFG_SEGMENT_SIZE, 32'd1460),
      write_row(CFG_INITIAL_THRESHOLD, 32'd2920),
      write_row(CFG_INITIAL_WINDOW, 32'd0),
      known_row(FUNC_ACK, 16'd5, 32'd0, 32'd2920, 32'd2920, 16'd3),
      write_row(CFG_SEGMENT_SIZE, 32'd65535),
      write_row(CFG_INITIAL_THRESHOLD, 32'hFFFF_FFFF),
      write_row(CFG_INITIAL_WINDOW, 32'hFFFF_FFF0),
      known_row(FUNC_ACK, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF),
      op_row(FUNC_ACK, 16'hFFFF, 32'd0),
      op_row(FUNC_ACK, 16'hFFFF, 32'd0),
      write_row(CFG_IDX_SPARE, 32'h1234_5678),
      op_row(FUNC_NOP, 16'd0, 32'd0)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        wait_idle();
        config_write(directed_steps[i].reg_idx, directed_steps[i].reg_data);
      end else begin
        send_item(directed_steps[i].op, directed_steps[i].acked, directed_steps[i].value,
                  directed_steps[i].known, directed_steps[i].result);
      end
    end
    directed_items = items_sent;

    for (int p = 1; p <= NUM_PHASES; p++) begin
      wait_idle();
      phase_no <= p;
      case (p)
        1: begin
          seg_set = 16'd1460;
          win_set = 32'd1460;
          thr_set = 32'hFFFF_FFFF;
        end
        2: begin
          seg_set = 16'd1;
          win_set = 32'd1;
          thr_set = $urandom_range(1, 1 << 20);
        end
        3: begin
          seg_set = 16'hFFFF;
          win_set = 32'hFFFF_FFFF;
          thr_set = 32'd1;
        end
        4: begin
          seg_set = 16'd0;
          win_set = 32'd0;
          thr_set = 32'hFFFF_FFFF;
        end
        5: begin
          seg_set = 16'd536;
          win_set = $urandom_range(0, 100000);
          thr_set = $urandom();
        end
        default: begin
          seg_set = SEG_W'($urandom());
          win_set = $urandom();
          thr_set = $urandom();
        end
      endcase
      config_write(CFG_SEGMENT_SIZE, 32'(seg_set));
      config_write(CFG_INITIAL_WINDOW, win_set);
      config_write(CFG_INITIAL_THRESHOLD, thr_set);
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    in_valid_i <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d directed and %0d random items, checked %0d results, %0d register writes.",
             directed_items, items_sent - directed_items, results_checked, register_writes);
    $display("Acks took slow start %0d times and congestion avoidance %0d times.",
             slow_start_acks, avoidance_acks);
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
